// ===== src/kmd_pkg.sv =====
// kmd_pkg: shared types and constants for the key matrix debouncer
// used by the channel interfaces, the per-key lane, the merge stage and the top level
package kmd_pkg;

  localparam int ROW_W = 3;
  localparam int COL_W = 13;
  localparam int CNT_W = 7;

  localparam logic [CNT_W-1:0] THRESH_RESET = 7'd5;

  // what one key lane reports for the current transaction
  typedef struct packed {
    logic             changed;
    logic             down;
    logic [CNT_W-1:0] count;
  } lane_out_t;

  // one result item
  typedef struct packed {
    logic [ROW_W-1:0] result_row;
    logic [COL_W-1:0] changed_mask;
    logic [COL_W-1:0] debounced_row;
    logic             activity;
  } result_t;

endpackage

// ===== src/kmd_row_if.sv =====
// kmd_row_if: input channel carrying one scanned matrix row
// depends on kmd_pkg for field widths
interface kmd_row_if;
  logic                      valid;
  logic                      ready;
  logic [kmd_pkg::ROW_W-1:0] row_index;
  logic [kmd_pkg::COL_W-1:0] column_levels;

  modport source (output valid, output row_index, output column_levels, input ready);
  modport sink   (input valid, input row_index, input column_levels, output ready);
endinterface

// ===== src/kmd_result_if.sv =====
// kmd_result_if: result channel carrying the debounced row and change mask
// depends on kmd_pkg for field widths
interface kmd_result_if;
  logic                      valid;
  logic                      ready;
  logic [kmd_pkg::ROW_W-1:0] result_row;
  logic [kmd_pkg::COL_W-1:0] changed_mask;
  logic [kmd_pkg::COL_W-1:0] debounced_row;
  logic                      activity;

  modport source (output valid, output result_row, output changed_mask,
                  output debounced_row, output activity, input ready);
  modport sink   (input valid, input result_row, input changed_mask,
                  input debounced_row, input activity, output ready);
endinterface

// ===== src/kmd_lane.sv =====
// kmd_lane: debounce update for one key of the sampled row
// depends on kmd_pkg for the lane result struct
module kmd_lane (
  input  logic                      en,
  input  logic                      level,
  input  logic                      down_i,
  input  logic [kmd_pkg::CNT_W-1:0] count_i,
  input  logic [kmd_pkg::CNT_W-1:0] thresh,
  output kmd_pkg::lane_out_t        lane_o
);

  logic                      pressed;
  logic                      mismatch;
  logic [kmd_pkg::CNT_W-1:0] cnt_inc;
  logic                      flip;

  assign pressed  = ~level;
  assign mismatch = pressed != down_i;
  assign cnt_inc  = count_i + kmd_pkg::CNT_W'(1);
  assign flip     = mismatch && (cnt_inc >= thresh);

  always_comb begin
    lane_o = '0;
    if (en) begin
      lane_o.changed = flip;
      lane_o.down    = flip ? pressed : down_i;
      if (!mismatch || flip) begin
        lane_o.count = '0;
      end else begin
        lane_o.count = cnt_inc;
      end
    end
  end

endmodule

// ===== src/kmd_merge.sv =====
// kmd_merge: gathers the lane results into masks and holds them in a two-entry output buffer
// depends on kmd_pkg and kmd_result_if
module kmd_merge #(
  parameter int LANES = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [kmd_pkg::ROW_W-1:0] row,
  input  kmd_pkg::lane_out_t        lanes [LANES],
  output logic                      ready,
  kmd_result_if.source              out_ch
);

  kmd_pkg::result_t res;
  logic [kmd_pkg::COL_W-1:0] chg;
  logic [kmd_pkg::COL_W-1:0] dbn;

  kmd_pkg::result_t main_r;
  kmd_pkg::result_t skid_r;
  logic             main_valid_r;
  logic             skid_valid_r;

  for (genvar b = 0; b < kmd_pkg::COL_W; b++) begin : g_bits
    if (b < LANES) begin : g_lane
      assign chg[b] = lanes[b].changed;
      assign dbn[b] = lanes[b].down;
    end else begin : g_pad
      assign chg[b] = 1'b0;
      assign dbn[b] = 1'b0;
    end
  end

  always_comb begin
    res.result_row    = row;
    res.changed_mask  = chg;
    res.debounced_row = dbn;
    res.activity      = |chg;
  end

  assign ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ch.ready) begin
      // output slot free: drain the skid entry first
      if (skid_valid_r) begin
        main_r       <= skid_r;
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_r       <= res;
        main_valid_r <= take;
      end
    end else if (take) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid         = main_valid_r;
  assign out_ch.result_row    = main_r.result_row;
  assign out_ch.changed_mask  = main_r.changed_mask;
  assign out_ch.debounced_row = main_r.debounced_row;
  assign out_ch.activity      = main_r.activity;

endmodule

// ===== src/key_matrix_debounce.sv =====
// key_matrix_debounce: counter debouncer for a scanned key matrix, one row per transaction
// result registered in the output buffer (skid entry while output stalls); 1 row per cycle
// unless full, set by the read-modify-write of the row's key state held in flip-flops
// a two-entry output buffer keeps input accepting while one result waits
// reset (rst_n low, synchronous): all keys up, all counters zero, threshold 5, buffer empty
// depends on kmd_pkg, kmd_row_if, kmd_result_if, kmd_lane and kmd_merge
module key_matrix_debounce #(
  parameter int ROW_COUNT    = 5,
  parameter int COLUMN_COUNT = 13,
  parameter int KEY_COUNT    = 65
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kmd_pkg::CNT_W-1:0] cfg_wdata,
  kmd_row_if.sink                   in_ch,
  kmd_result_if.source              out_ch
);

  // only rows reachable by the row field and columns inside the level field are stored
  localparam int ROWS   = (ROW_COUNT < (1 << kmd_pkg::ROW_W)) ? ROW_COUNT : (1 << kmd_pkg::ROW_W);
  localparam int LANES  = (COLUMN_COUNT < kmd_pkg::COL_W) ? COLUMN_COUNT : kmd_pkg::COL_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW     = $clog2((1 << kmd_pkg::ROW_W) * COLUMN_COUNT + COLUMN_COUNT + 1);

  logic [kmd_pkg::CNT_W-1:0] thresh_r;

  logic                      down_r  [ROWS][LANES];
  logic [kmd_pkg::CNT_W-1:0] count_r [ROWS][LANES];

  logic [ROW_AW-1:0]         row_sel;
  logic                      row_ok;
  logic [KW-1:0]             row_base;
  logic                      take;
  logic                      lane_en [LANES];
  kmd_pkg::lane_out_t        lane_res [LANES];

  assign row_sel  = in_ch.row_index[ROW_AW-1:0];
  assign row_ok   = 32'(in_ch.row_index) < 32'(ROW_COUNT);
  assign row_base = KW'(in_ch.row_index) * KW'(COLUMN_COUNT);
  assign take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= kmd_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lanes
    logic [KW-1:0] key_idx;
    logic          st_down;
    logic [kmd_pkg::CNT_W-1:0] st_count;

    assign key_idx    = row_base + KW'(j);
    assign lane_en[j] = row_ok && (32'(key_idx) < 32'(KEY_COUNT));
    assign st_down    = row_ok ? down_r[row_sel][j] : 1'b0;
    assign st_count   = row_ok ? count_r[row_sel][j] : '0;

    kmd_lane u_lane (
      .en      (lane_en[j]),
      .level   (in_ch.column_levels[j]),
      .down_i  (st_down),
      .count_i (st_count),
      .thresh  (thresh_r),
      .lane_o  (lane_res[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < LANES; c++) begin
          down_r[r][c]  <= 1'b0;
          count_r[r][c] <= '0;
        end
      end
    end else if (take) begin
      for (int c = 0; c < LANES; c++) begin
        if (lane_en[c]) begin
          down_r[row_sel][c]  <= lane_res[c].down;
          count_r[row_sel][c] <= lane_res[c].count;
        end
      end
    end
  end

  kmd_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .row    (in_ch.row_index),
    .lanes  (lane_res),
    .ready  (in_ch.ready),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/sv/key_matrix_debounce_checker.sv =====
// key_matrix_debounce_checker: watches the row and result channels, keeps its own copy
// of every key's debounced state and counter, and compares each result in order
// depends on kmd_pkg, kmd_row_if and kmd_result_if
`timescale 1ns / 1ps

module key_matrix_debounce_checker #(
  parameter int ROW_COUNT    = 5,
  parameter int COLUMN_COUNT = 13,
  parameter int KEY_COUNT    = 65
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kmd_pkg::CNT_W-1:0] cfg_wdata,
  kmd_row_if                        row_mon,
  kmd_result_if                     res_mon,
  output int                        fail_count,
  output int                        outstanding
);
  import kmd_pkg::*;

  logic [CNT_W-1:0] threshold;
  logic             key_down  [KEY_COUNT];
  logic [CNT_W-1:0] disagree_cnt [KEY_COUNT];
  result_t          expected_rows [$];

  function automatic result_t predict_row_scan(logic [ROW_W-1:0] row,
                                               logic [COL_W-1:0] levels);
    result_t    res;
    int         key;
    logic       pressed;
    logic [CNT_W-1:0] cnt;
    res = '0;
    res.result_row = row;
    if (row < ROW_COUNT) begin
      for (int j = 0; j < COLUMN_COUNT && j < COL_W; j++) begin
        key = int'(row) * COLUMN_COUNT + j;
        if (key < KEY_COUNT) begin
          pressed = ~levels[j];
          if (pressed != key_down[key]) begin
            cnt = disagree_cnt[key] + 1'b1;
            // a threshold of zero flips on the first disagreeing sample
            if (cnt >= threshold) begin
              key_down[key] = pressed;
              cnt = '0;
              res.changed_mask[j] = 1'b1;
            end
            disagree_cnt[key] = cnt;
          end else begin
            disagree_cnt[key] = '0;
          end
          res.debounced_row[j] = key_down[key];
        end
      end
    end
    res.activity = |res.changed_mask;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      threshold = THRESH_RESET;
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_down[k]     = 1'b0;
        disagree_cnt[k] = '0;
      end
      expected_rows.delete();
      fail_count = 0;
    end else begin
      // result first: it belongs to an earlier transaction than any input at this edge
      if (res_mon.valid && res_mon.ready) begin
        got.result_row    = res_mon.result_row;
        got.changed_mask  = res_mon.changed_mask;
        got.debounced_row = res_mon.debounced_row;
        got.activity      = res_mon.activity;
        if (expected_rows.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result row %0d changed %h debounced %h activity %b",
                     $realtime, got.result_row, got.changed_mask, got.debounced_row,
                     got.activity);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (got.result_row != want.result_row || got.changed_mask != want.changed_mask ||
              got.debounced_row != want.debounced_row || got.activity != want.activity) begin
            if (fail_count < 10)
              $display("%0t: mismatch expected row %0d changed %h debounced %h activity %b, %s",
                       $realtime, want.result_row, want.changed_mask, want.debounced_row,
                       want.activity,
                       $sformatf("got row %0d changed %h debounced %h activity %b",
                                 got.result_row, got.changed_mask, got.debounced_row,
                                 got.activity));
            fail_count++;
          end
        end
      end
      if (row_mon.valid && row_mon.ready)
        expected_rows.push_back(predict_row_scan(row_mon.row_index, row_mon.column_levels));
      if (cfg_we)
        threshold = cfg_wdata;
    end
    outstanding = expected_rows.size();
  end

endmodule

// ===== tb/sv/key_matrix_debounce_tb.sv =====
// key_matrix_debounce_tb: drives scanned key matrix rows through several debounce
// thresholds with bursty input and a stalling result sink; the checker gives the verdict
// depends on kmd_pkg, the channel interfaces, key_matrix_debounce and its checker
`timescale 1ns / 1ps

module key_matrix_debounce_tb;
  import kmd_pkg::*;

  localparam int ROW_COUNT    = 5;
  localparam int COLUMN_COUNT = 13;
  localparam int KEY_COUNT    = 65;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int NO_FOCUS     = -1;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_wdata;
  int                  fail_count;
  int                  outstanding;
  int                  cycles;
  int                  burst_left;
  int                  scan_pos;
  logic [COL_W-1:0]    held_keys [ROW_COUNT];

  kmd_row_if    row_ch ();
  kmd_result_if res_ch ();

  key_matrix_debounce #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT),
    .KEY_COUNT    (KEY_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (row_ch),
    .out_ch    (res_ch)
  );

  key_matrix_debounce_checker #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT),
    .KEY_COUNT    (KEY_COUNT)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .row_mon     (row_ch),
    .res_mon     (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result sink: stretches of always-ready, random stalls and a rotating stall pattern
  initial begin
    sink_mode_e mode;
    int         stretch;
    logic [7:0] pattern;
    res_ch.ready = 1'b0;
    forever begin
      mode    = sink_mode_e'($urandom_range(2));
      stretch = $urandom_range(10, 60);
      pattern = 8'($urandom);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          SINK_ALWAYS: res_ch.ready = 1'b1;
          SINK_RANDOM: res_ch.ready = ($urandom_range(3) != 0);
          default: begin
            res_ch.ready = pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction, or after an idle gap when a burst ends
  task automatic send_row(logic [ROW_W-1:0] row, logic [COL_W-1:0] levels);
    int gap;
    row_ch.valid         = 1'b1;
    row_ch.row_index     = row;
    row_ch.column_levels = levels;
    do @(posedge clk); while (!row_ch.ready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      row_ch.valid         = 1'b0;
      row_ch.row_index     = ROW_W'($urandom);
      row_ch.column_levels = COL_W'($urandom);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // sender holds off until every result is back, then writes the threshold
  task automatic drain_and_set_threshold(logic [CNT_W-1:0] value);
    row_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // matrix scan: rows in order against a slowly changing key matrix, with contact
  // bounce, out-of-range rows and some fully random rows as noise
  task automatic scan_matrix(int count, int focus_row, int focus_pct);
    int               row;
    int               pick;
    logic [COL_W-1:0] levels;
    repeat (count) begin
      pick = $urandom_range(99);
      if (focus_row != NO_FOCUS && pick < focus_pct) begin
        row = focus_row;
      end else if (pick >= 95) begin
        row = $urandom_range(ROW_COUNT, 7);
      end else begin
        row = scan_pos;
        scan_pos = (scan_pos + 1) % ROW_COUNT;
      end
      if ($urandom_range(99) < 4) begin
        pick = $urandom_range(ROW_COUNT - 1);
        if (pick != focus_row)
          held_keys[pick][$urandom_range(COL_W - 1)] ^= 1'b1;
      end
      if (row >= ROW_COUNT || $urandom_range(99) < 5) begin
        levels = COL_W'($urandom);
      end else begin
        levels = ~held_keys[row];
        if (row != focus_row && $urandom_range(99) < 10)
          levels ^= COL_W'($urandom & $urandom & $urandom);
      end
      send_row(ROW_W'(row), levels);
    end
  endtask

  initial begin
    int focus;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    row_ch.valid         = 1'b0;
    row_ch.row_index     = '0;
    row_ch.column_levels = '0;
    burst_left           = 8;
    scan_pos             = 0;
    for (int r = 0; r < ROW_COUNT; r++)
      held_keys[r] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset threshold of five: press and release a whole row
    repeat (5) send_row(3'd0, 13'h0000);
    send_row(3'd5, 13'h0000);
    send_row(3'd6, 13'h1FFF);
    send_row(3'd7, 13'h0000);
    repeat (5) send_row(3'd0, 13'h1FFF);
    // an agreeing sample clears the counters before the threshold is reached
    repeat (4) send_row(3'd4, 13'h0000);
    send_row(3'd4, 13'h1FFF);
    repeat (5) send_row(3'd4, 13'h0000);
    held_keys[4] = 13'h1FFF;

    drain_and_set_threshold(7'd1);
    scan_matrix(150, NO_FOCUS, 0);

    drain_and_set_threshold(7'd0);
    scan_matrix(100, NO_FOCUS, 0);

    // largest threshold: hold one row steady long enough to flip its keys
    drain_and_set_threshold(7'd127);
    focus = $urandom_range(ROW_COUNT - 1);
    held_keys[focus] = COL_W'($urandom);
    scan_matrix(260, focus, 67);

    drain_and_set_threshold(7'd3);
    scan_matrix(200, NO_FOCUS, 0);

    drain_and_set_threshold(7'($urandom_range(2, 10)));
    scan_matrix(200, NO_FOCUS, 0);

    row_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/kmd_pkg.sv
src/kmd_row_if.sv
src/kmd_result_if.sv
src/kmd_lane.sv
src/kmd_merge.sv
src/key_matrix_debounce.sv
tb/sv/key_matrix_debounce_checker.sv
tb/sv/key_matrix_debounce_tb.sv
